@@ design/assert_macros.svh @@
// Assertion macros shared by the positioner RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define SAP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define SAP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

@@ design/sap_pkg.sv @@
// Shared types and constants for the stepper angle positioner.
// No dependencies; imported by sap_prep, sap_core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sap_pkg;

  // Field widths of the request and result channels.
  localparam int MODE_W = 3;
  localparam int AMT_W  = 10;
  localparam int ANG_W  = 9;
  localparam int REM_W  = 9;
  localparam int HOLD_W = 16;
  localparam int COIL_W = 4;

  // Degrees in one full turn, used for the step scaling.
  localparam int DEG_PER_TURN = 360;

  // Reset value of the phase hold register.
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd5;

  // Request codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK = 3'd0,
    MODE_SET  = 3'd1,
    MODE_INC  = 3'd2,
    MODE_DEC  = 3'd3,
    MODE_HOME = 3'd4
  } mode_t;

  // Motion state, one-hot.
  typedef enum logic [2:0] {
    MOT_IDLE = 3'b001,
    MOT_MOVE = 3'b010,
    MOT_HOME = 3'b100
  } motion_t;

  // Full-step coil sequences for each direction.
  localparam logic [COIL_W-1:0] RIGHT_SEQ [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
  localparam logic [COIL_W-1:0] LEFT_SEQ  [4] = '{4'hC, 4'h6, 4'h3, 4'h9};

  function automatic logic [COIL_W-1:0] coil_pattern(input logic right, input logic [1:0] ph);
    coil_pattern = right ? RIGHT_SEQ[ph] : LEFT_SEQ[ph];
  endfunction

endpackage

`default_nettype wire

@@ design/sap_prep.sv @@
// Request pre-processing pipeline: reduces the amount modulo the wrap angle and
// converts it to a step count with remainder. Depends on sap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sap_prep
  import sap_pkg::*;
#(
  parameter int WRAP_DEGREES   = 350,
  parameter int STEPS_PER_TURN = 512
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [MODE_W-1:0]    in_mode,
  input  wire logic [AMT_W-1:0]     in_amount,
  input  wire logic                 in_end_stop,
  output logic                      p_valid,
  input  wire logic                 p_ready,
  output logic [MODE_W-1:0]         p_mode,
  output logic [ANG_W-1:0]          p_amt_mod,
  output logic [$clog2(STEPS_PER_TURN)-1:0] p_tq,
  output logic [REM_W-1:0]          p_tr,
  output logic                      p_end_stop
);

  localparam int POS_W  = $clog2(STEPS_PER_TURN);
  localparam int NSTAGE = 5;

  // Reciprocal of the wrap angle; exact for any 10-bit amount.
  localparam int KA     = 20;
  localparam int RA_W   = KA + 1;
  localparam int PA_W   = AMT_W + RA_W;
  localparam longint unsigned RA = ((64'd1 << KA) + WRAP_DEGREES - 1) / WRAP_DEGREES;

  // Scaled ratio steps/degrees; exact for any angle below a full turn.
  localparam int KS     = 24;
  localparam int RS_W   = 28;
  localparam int PS_W   = ANG_W + RS_W;
  localparam longint unsigned RS =
    ((longint'(STEPS_PER_TURN) << KS) + DEG_PER_TURN - 1) / DEG_PER_TURN;

  localparam int PB_W   = 2 * AMT_W;
  localparam int PD_W   = 21;

  // Stage valid bits and load enables.
  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] ld;

  // Stage registers.
  logic [MODE_W-1:0] s0_mode_r, s1_mode_r, s2_mode_r, s3_mode_r, s4_mode_r;
  logic              s0_es_r, s1_es_r, s2_es_r, s3_es_r, s4_es_r;
  logic [AMT_W-1:0]  s0_amount_r, s1_amount_r;
  logic [AMT_W-1:0]  s1_qa_r;
  logic [ANG_W-1:0]  s2_m_r, s3_m_r, s4_m_r;
  logic [POS_W-1:0]  s3_qt_r, s4_tq_r;
  logic [REM_W-1:0]  s4_tr_r;

  logic [PA_W-1:0]   prod_a;
  logic [AMT_W-1:0]  qa_nxt;
  logic [PB_W-1:0]   prod_b;
  logic [ANG_W-1:0]  m_nxt;
  logic [PS_W-1:0]   prod_c;
  logic [POS_W-1:0]  qt_nxt;
  logic [PD_W-1:0]   prod_d;
  logic [REM_W-1:0]  tr_nxt;

  // A stage loads when empty or when its content moves on.
  always_comb begin
    ld[NSTAGE-1] = !vld_r[NSTAGE-1] || p_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      ld[i] = !vld_r[i] || ld[i+1];
    end
  end

  assign in_stall = !ld[0];

  // Quotient estimate of amount / wrap.
  assign prod_a = PA_W'(s0_amount_r) * PA_W'(RA);
  assign qa_nxt = prod_a[KA +: AMT_W];

  // Amount modulo wrap.
  assign prod_b = PB_W'(s1_qa_r) * PB_W'(WRAP_DEGREES);
  assign m_nxt  = ANG_W'(s1_amount_r - prod_b[AMT_W-1:0]);

  // Step count of the reduced angle.
  assign prod_c = PS_W'(s2_m_r) * PS_W'(RS);
  assign qt_nxt = prod_c[KS +: POS_W];

  // Remainder of the step scaling, in degree units.
  assign prod_d = PD_W'(s3_m_r) * PD_W'(STEPS_PER_TURN)
                - PD_W'(s3_qt_r) * PD_W'(DEG_PER_TURN);
  assign tr_nxt = prod_d[REM_W-1:0];

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NSTAGE; i++) begin
        if (ld[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ld[0] && in_valid) begin
      s0_mode_r   <= in_mode;
      s0_es_r     <= in_end_stop;
      s0_amount_r <= in_amount;
    end
    if (ld[1] && vld_r[0]) begin
      s1_mode_r   <= s0_mode_r;
      s1_es_r     <= s0_es_r;
      s1_amount_r <= s0_amount_r;
      s1_qa_r     <= qa_nxt;
    end
    if (ld[2] && vld_r[1]) begin
      s2_mode_r <= s1_mode_r;
      s2_es_r   <= s1_es_r;
      s2_m_r    <= m_nxt;
    end
    if (ld[3] && vld_r[2]) begin
      s3_mode_r <= s2_mode_r;
      s3_es_r   <= s2_es_r;
      s3_m_r    <= s2_m_r;
      s3_qt_r   <= qt_nxt;
    end
    if (ld[4] && vld_r[3]) begin
      s4_mode_r <= s3_mode_r;
      s4_es_r   <= s3_es_r;
      s4_m_r    <= s3_m_r;
      s4_tq_r   <= s3_qt_r;
      s4_tr_r   <= tr_nxt;
    end
  end

  assign p_valid    = vld_r[NSTAGE-1];
  assign p_mode     = s4_mode_r;
  assign p_amt_mod  = s4_m_r;
  assign p_tq       = s4_tq_r;
  assign p_tr       = s4_tr_r;
  assign p_end_stop = s4_es_r;

endmodule

`default_nettype wire

@@ design/sap_core.sv @@
// Positioner state machine, phase hold register and result register.
// Depends on sap_pkg; fed by sap_prep.
`timescale 1ns / 1ps
`default_nettype none

module sap_core
  import sap_pkg::*;
#(
  parameter int WRAP_DEGREES   = 350,
  parameter int STEPS_PER_TURN = 512
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [HOLD_W-1:0]    cfg_wr_data,
  input  wire logic                 p_valid,
  output logic                      p_ready,
  input  wire logic [MODE_W-1:0]    p_mode,
  input  wire logic [ANG_W-1:0]     p_amt_mod,
  input  wire logic [$clog2(STEPS_PER_TURN)-1:0] p_tq,
  input  wire logic [REM_W-1:0]     p_tr,
  input  wire logic                 p_end_stop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [COIL_W-1:0]         out_coils,
  output logic                      out_led,
  output logic                      out_busy_res,
  output logic [ANG_W-1:0]          out_angle,
  output logic                      out_rejected
);

  localparam int POS_W = $clog2(STEPS_PER_TURN);
  localparam int SUM_W = ANG_W + 1;

  // Step count and remainder of one full wrap angle.
  localparam logic [POS_W-1:0] WQ_C =
    POS_W'((WRAP_DEGREES * STEPS_PER_TURN) / DEG_PER_TURN);
  localparam logic [REM_W-1:0] WR_C =
    REM_W'((WRAP_DEGREES * STEPS_PER_TURN) % DEG_PER_TURN);
  localparam logic [SUM_W-1:0] WRAP_C = SUM_W'(WRAP_DEGREES);
  localparam logic [SUM_W-1:0] TURN_C = SUM_W'(DEG_PER_TURN);

  logic [HOLD_W-1:0] phase_hold_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  tgt_r, tgt_nxt;
  logic [REM_W-1:0]  trem_r, trem_nxt;
  logic [ANG_W-1:0]  ang_r, ang_nxt;
  motion_t           motion_r, motion_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [HOLD_W-1:0] hold_r, hold_nxt;
  logic              led_r, led_nxt;
  logic              out_valid_r;
  logic [COIL_W-1:0] coils_r, coils_nxt;
  logic              led_out_r;
  logic              busy_r;
  logic [ANG_W-1:0]  angle_r;
  logic              rej_r, rej_nxt;

  logic              fire;
  logic              busy;
  mode_t             mode;
  logic [HOLD_W-1:0] hold_lim;
  logic              go_right;
  logic [POS_W-1:0]  pos_step;

  // Increment path.
  logic [SUM_W-1:0]  ang_sum;
  logic              inc_wrap;
  logic [ANG_W-1:0]  inc_ang;
  logic [SUM_W-1:0]  rem_sum;
  logic              rem_c;
  logic [REM_W-1:0]  rem_a;
  logic [POS_W-1:0]  q_a;
  logic              inc_borrow;
  logic [REM_W-1:0]  inc_rem;
  logic [POS_W-1:0]  inc_tgt;

  // Decrement path.
  logic              dec_under;
  logic [ANG_W-1:0]  dec_ang;
  logic              rem_b;
  logic [REM_W-1:0]  rem_d;
  logic [POS_W-1:0]  q_d;
  logic [SUM_W-1:0]  rem_s;
  logic              dec_c;
  logic [REM_W-1:0]  dec_rem;
  logic [POS_W-1:0]  dec_tgt;

  // Chosen new angle for set, increment and decrement.
  logic [ANG_W-1:0]  new_ang;
  logic [POS_W-1:0]  new_tgt;
  logic [REM_W-1:0]  new_rem;

  assign p_ready  = !out_valid_r || !out_stall;
  assign fire     = p_valid && p_ready;
  assign busy     = (motion_r != MOT_IDLE);
  assign mode     = mode_t'(p_mode);
  assign hold_lim = (phase_hold_r == '0) ? HOLD_W'(1) : phase_hold_r;
  assign go_right = (pos_r < tgt_r);
  assign pos_step = go_right ? pos_r + POS_W'(1) : pos_r - POS_W'(1);

  // Increment: the target keeps step count and remainder, so adding angles
  // adds both parts with a carry; a wrap takes off one wrap angle.
  always_comb begin
    ang_sum    = SUM_W'(ang_r) + SUM_W'(p_amt_mod);
    inc_wrap   = (ang_sum >= WRAP_C);
    inc_ang    = inc_wrap ? ANG_W'(ang_sum - WRAP_C) : ang_sum[ANG_W-1:0];
    rem_sum    = SUM_W'(trem_r) + SUM_W'(p_tr);
    rem_c      = (rem_sum >= TURN_C);
    rem_a      = rem_c ? REM_W'(rem_sum - TURN_C) : rem_sum[REM_W-1:0];
    q_a        = tgt_r + p_tq + POS_W'(rem_c);
    inc_borrow = (rem_a < WR_C);
    if (!inc_wrap) begin
      inc_rem = rem_a;
    end else if (inc_borrow) begin
      inc_rem = REM_W'(SUM_W'(rem_a) + TURN_C - SUM_W'(WR_C));
    end else begin
      inc_rem = rem_a - WR_C;
    end
    inc_tgt = inc_wrap ? q_a - WQ_C - POS_W'(inc_borrow) : q_a;
  end

  // Decrement: subtract both parts with a borrow; going below zero adds
  // one wrap angle back.
  always_comb begin
    dec_under = (ang_r < p_amt_mod);
    dec_ang   = dec_under ? ANG_W'(SUM_W'(ang_r) + WRAP_C - SUM_W'(p_amt_mod))
                          : ang_r - p_amt_mod;
    rem_b     = (trem_r < p_tr);
    rem_d     = rem_b ? REM_W'(SUM_W'(trem_r) + TURN_C - SUM_W'(p_tr))
                      : trem_r - p_tr;
    q_d       = tgt_r - p_tq - POS_W'(rem_b);
    rem_s     = SUM_W'(rem_d) + SUM_W'(WR_C);
    dec_c     = (rem_s >= TURN_C);
    if (!dec_under) begin
      dec_rem = rem_d;
    end else if (dec_c) begin
      dec_rem = REM_W'(rem_s - TURN_C);
    end else begin
      dec_rem = rem_s[REM_W-1:0];
    end
    dec_tgt = dec_under ? q_d + WQ_C + POS_W'(dec_c) : q_d;
  end

  // Select the new angle by request code.
  always_comb begin
    unique case (mode)
      MODE_INC: begin
        new_ang = inc_ang;
        new_tgt = inc_tgt;
        new_rem = inc_rem;
      end
      MODE_DEC: begin
        new_ang = dec_ang;
        new_tgt = dec_tgt;
        new_rem = dec_rem;
      end
      default: begin
        new_ang = p_amt_mod;
        new_tgt = p_tq;
        new_rem = p_tr;
      end
    endcase
  end

  // Next state for one request.
  always_comb begin
    pos_nxt    = pos_r;
    tgt_nxt    = tgt_r;
    trem_nxt   = trem_r;
    ang_nxt    = ang_r;
    motion_nxt = motion_r;
    phase_nxt  = phase_r;
    hold_nxt   = hold_r;
    led_nxt    = led_r;
    rej_nxt    = 1'b0;
    if (fire) begin
      unique case (mode)
        MODE_TICK: begin
          if (busy) begin
            priority if (hold_r == '0) begin
              // Step boundary: finish the move, end homing or start a step.
              priority if (motion_r == MOT_MOVE && pos_r == tgt_r) begin
                motion_nxt = MOT_IDLE;
              end else if (motion_r == MOT_HOME && !p_end_stop) begin
                pos_nxt    = '0;
                tgt_nxt    = '0;
                trem_nxt   = '0;
                ang_nxt    = '0;
                led_nxt    = 1'b0;
                motion_nxt = MOT_IDLE;
              end else begin
                phase_nxt = 2'd0;
                hold_nxt  = HOLD_W'(1);
              end
            end else if (hold_r < hold_lim) begin
              hold_nxt = hold_r + HOLD_W'(1);
            end else if (phase_r != 2'd3) begin
              phase_nxt = phase_r + 2'd1;
              hold_nxt  = HOLD_W'(1);
            end else begin
              // Last pattern done: switch off and, during a move, count the step.
              if (motion_r == MOT_MOVE) begin
                pos_nxt = pos_step;
                if (pos_step == tgt_r) motion_nxt = MOT_IDLE;
              end
              phase_nxt = 2'd0;
              hold_nxt  = '0;
            end
          end
        end
        MODE_SET, MODE_INC, MODE_DEC: begin
          if (busy) begin
            rej_nxt = 1'b1;
          end else begin
            ang_nxt    = new_ang;
            tgt_nxt    = new_tgt;
            trem_nxt   = new_rem;
            phase_nxt  = 2'd0;
            hold_nxt   = '0;
            motion_nxt = (new_tgt != pos_r) ? MOT_MOVE : MOT_IDLE;
          end
        end
        MODE_HOME: begin
          if (busy) begin
            rej_nxt = 1'b1;
          end else begin
            motion_nxt = MOT_HOME;
            led_nxt    = 1'b1;
            phase_nxt  = 2'd0;
            hold_nxt   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Coil drive after the update; position only moves when the coils go off.
  always_comb begin
    if (hold_nxt != '0 && motion_nxt != MOT_IDLE) begin
      coils_nxt = coil_pattern(motion_nxt == MOT_MOVE && go_right, phase_nxt);
    end else begin
      coils_nxt = '0;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_hold_r <= HOLD_RESET;
      pos_r        <= '0;
      tgt_r        <= '0;
      trem_r       <= '0;
      ang_r        <= '0;
      motion_r     <= MOT_IDLE;
      phase_r      <= 2'd0;
      hold_r       <= '0;
      led_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) phase_hold_r <= cfg_wr_data;
      pos_r    <= pos_nxt;
      tgt_r    <= tgt_nxt;
      trem_r   <= trem_nxt;
      ang_r    <= ang_nxt;
      motion_r <= motion_nxt;
      phase_r  <= phase_nxt;
      hold_r   <= hold_nxt;
      led_r    <= led_nxt;
      if (p_ready) out_valid_r <= p_valid;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (fire) begin
      coils_r   <= coils_nxt;
      led_out_r <= led_nxt;
      busy_r    <= (motion_nxt != MOT_IDLE);
      angle_r   <= ang_nxt;
      rej_r     <= rej_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_coils    = coils_r;
  assign out_led      = led_out_r;
  assign out_busy_res = busy_r;
  assign out_angle    = angle_r;
  assign out_rejected = rej_r;

endmodule

`default_nettype wire

@@ design/stepper_angle_positioner.sv @@
// Top level of the stepper angle positioner: pre-processing pipeline plus
// positioner core. Depends on sap_pkg, sap_prep, sap_core, assert_macros.svh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   in_     | request   | in_valid / in_stall  | in_mode, in_amount, in_end_stop
//   out_    | result    | out_valid / out_stall| out_coils, out_led, out_busy_res,
//           |           |                      |   out_angle, out_rejected
//   cfg_    | write     | cfg_wr_en            | cfg_wr_data (phase hold ticks)
//
// One request per cycle is accepted while in_stall is low. Each result passes through
// the pre-processing stages, whose multiplies reduce the amount modulo the wrap
// angle and scale it to steps, and then through the core's result register.
// rst_n is synchronous and active low; it clears the motion state and sets
// the phase hold to five ticks. A stalled result holds only the stages whose
// successors are full; empty stages keep taking requests.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module stepper_angle_positioner
  import sap_pkg::*;
#(
  parameter int WRAP_DEGREES   = 350,
  parameter int STEPS_PER_TURN = 512
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [HOLD_W-1:0] cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [AMT_W-1:0]  in_amount,
  input  wire logic              in_end_stop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [COIL_W-1:0]      out_coils,
  output logic                   out_led,
  output logic                   out_busy_res,
  output logic [ANG_W-1:0]       out_angle,
  output logic                   out_rejected
);

  localparam int POS_W = $clog2(STEPS_PER_TURN);

  logic              prep_valid;
  logic              prep_ready;
  logic [MODE_W-1:0] prep_mode;
  logic [ANG_W-1:0]  prep_amt_mod;
  logic [POS_W-1:0]  prep_tq;
  logic [REM_W-1:0]  prep_tr;
  logic              prep_end_stop;

  // Amount reduction and step scaling.
  sap_prep #(
    .WRAP_DEGREES  (WRAP_DEGREES),
    .STEPS_PER_TURN(STEPS_PER_TURN)
  ) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_amount  (in_amount),
    .in_end_stop(in_end_stop),
    .p_valid    (prep_valid),
    .p_ready    (prep_ready),
    .p_mode     (prep_mode),
    .p_amt_mod  (prep_amt_mod),
    .p_tq       (prep_tq),
    .p_tr       (prep_tr),
    .p_end_stop (prep_end_stop)
  );

  // Motion state and result register.
  sap_core #(
    .WRAP_DEGREES  (WRAP_DEGREES),
    .STEPS_PER_TURN(STEPS_PER_TURN)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .p_valid     (prep_valid),
    .p_ready     (prep_ready),
    .p_mode      (prep_mode),
    .p_amt_mod   (prep_amt_mod),
    .p_tq        (prep_tq),
    .p_tr        (prep_tr),
    .p_end_stop  (prep_end_stop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_coils   (out_coils),
    .out_led     (out_led),
    .out_busy_res(out_busy_res),
    .out_angle   (out_angle),
    .out_rejected(out_rejected)
  );

  // A rejected request leaves the block busy.
  `SAP_ASSERT_IMPL(a_rej_busy, out_valid && out_rejected, out_busy_res, "reject while idle")
  // Coils are only driven during a move or homing.
  `SAP_ASSERT_IMPL(a_coil_busy, out_valid && (out_coils != 4'h0), out_busy_res, "coils on idle")
  // The homing light never stays on once the block is idle.
  `SAP_ASSERT_NEVER(a_led_idle, out_valid && out_led && !out_busy_res, "led lit while idle")
  // The reported angle is always wrapped.
  `SAP_ASSERT_IMPL(a_ang_wrap, out_valid, out_angle < ANG_W'(WRAP_DEGREES), "angle not wrapped")

endmodule

`default_nettype wire

@@ verif/tb_stepper_angle_positioner.sv @@
// Self-checking testbench for stepper_angle_positioner: a shadow of the motion
// state predicts every result, and random idling and stalls cover both handshakes.
// Depends on sap_pkg and the positioner RTL only.
`timescale 1ns / 1ps

module tb_stepper_angle_positioner;
  import sap_pkg::*;

  localparam int WRAP_DEG  = 350;
  localparam int STEPS_REV = 512;

  // Request codes the block must ignore.
  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

  // Full-step coil order for each direction of travel.
  localparam logic [COIL_W-1:0] FWD_COILS [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
  localparam logic [COIL_W-1:0] REV_COILS [4] = '{4'hC, 4'h6, 4'h3, 4'h9};

  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic              led;
    logic              busy;
    logic [ANG_W-1:0]  angle;
    logic              rejected;
  } coil_result_t;

  // Shadow of the positioner state; holds the results still owed by the block.
  class stepper_shadow;
    logic [HOLD_W-1:0] hold_ticks;
    logic [10:0]       step_pos;
    logic [9:0]        target_step;
    logic [ANG_W-1:0]  angle_now;
    motion_t           motion;
    logic [1:0]        phase;
    logic [HOLD_W-1:0] hold_cnt;
    logic              led;
    coil_result_t      owed_results[$];
    int                mismatches;
    int                n_requests;
    int                n_results;
    int                n_refused;
    int                n_homing;

    function new();
      hold_ticks  = HOLD_RESET;
      step_pos    = '0;
      target_step = '0;
      angle_now   = '0;
      motion      = MOT_IDLE;
      phase       = '0;
      hold_cnt    = '0;
      led         = 1'b0;
    endfunction

    function void set_hold(logic [HOLD_W-1:0] value);
      hold_ticks = value;
    endfunction

    function bit is_busy();
      return motion != MOT_IDLE;
    endfunction

    // Accepted move: new angle and the step it scales to.
    function void head_to(int deg);
      angle_now   = deg[ANG_W-1:0];
      target_step = 10'((deg * STEPS_REV) / DEG_PER_TURN);
      phase       = '0;
      hold_cnt    = '0;
      motion      = (target_step != step_pos) ? MOT_MOVE : MOT_IDLE;
    endfunction

    // One timer tick: walk the coil patterns, then move one step.
    function void advance_tick(logic end_stop);
      logic [HOLD_W-1:0] hold_lim;
      hold_lim = (hold_ticks == '0) ? 16'd1 : hold_ticks;
      if (motion == MOT_IDLE) return;
      if (hold_cnt == '0) begin
        if (motion == MOT_MOVE && step_pos == target_step) begin
          motion = MOT_IDLE;
          return;
        end
        if (motion == MOT_HOME && !end_stop) begin
          step_pos    = '0;
          target_step = '0;
          angle_now   = '0;
          led         = 1'b0;
          motion      = MOT_IDLE;
          return;
        end
        phase    = '0;
        hold_cnt = 16'd1;
      end else if (hold_cnt < hold_lim) begin
        hold_cnt++;
      end else if (phase < 2'd3) begin
        phase++;
        hold_cnt = 16'd1;
      end else begin
        if (motion == MOT_MOVE) begin
          if (step_pos < target_step) step_pos++;
          else step_pos--;
          if (step_pos == target_step) motion = MOT_IDLE;
        end
        phase    = '0;
        hold_cnt = '0;
      end
    endfunction

    // Applies an accepted request and queues the result it must produce.
    function void note_request(logic [MODE_W-1:0] mode, logic [AMT_W-1:0] amount,
                               logic end_stop);
      coil_result_t res;
      int           amt;
      amt = amount;
      res.rejected = 1'b0;
      case (mode)
        MODE_TICK: advance_tick(end_stop);
        MODE_SET, MODE_INC, MODE_DEC, MODE_HOME: begin
          if (motion != MOT_IDLE) begin
            res.rejected = 1'b1;
            n_refused++;
          end else if (mode == MODE_SET) begin
            head_to(amt % WRAP_DEG);
          end else if (mode == MODE_INC) begin
            head_to((angle_now + amt) % WRAP_DEG);
          end else if (mode == MODE_DEC) begin
            head_to((angle_now % WRAP_DEG + WRAP_DEG - amt % WRAP_DEG) % WRAP_DEG);
          end else begin
            motion   = MOT_HOME;
            led      = 1'b1;
            phase    = '0;
            hold_cnt = '0;
            n_homing++;
          end
        end
        default: ;
      endcase
      if (hold_cnt == '0 || motion == MOT_IDLE) res.coils = '0;
      else if (motion == MOT_MOVE && step_pos < target_step) res.coils = FWD_COILS[phase];
      else res.coils = REV_COILS[phase];
      res.led   = led;
      res.busy  = (motion != MOT_IDLE);
      res.angle = angle_now;
      owed_results.push_back(res);
      n_requests++;
    endfunction

    // Compares a delivered result with the oldest one owed.
    function void check_result(coil_result_t got);
      coil_result_t want;
      n_results++;
      if (owed_results.size() == 0) begin
        $error("result arrived with no request outstanding: %p", got);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      if (got.coils !== want.coils) begin
        $error("coils: expected %0h, got %0h", want.coils, got.coils);
        mismatches++;
      end
      if (got.led !== want.led) begin
        $error("led: expected %0b, got %0b", want.led, got.led);
        mismatches++;
      end
      if (got.busy !== want.busy) begin
        $error("busy_res: expected %0b, got %0b", want.busy, got.busy);
        mismatches++;
      end
      if (got.angle !== want.angle) begin
        $error("angle: expected %0d, got %0d", want.angle, got.angle);
        mismatches++;
      end
      if (got.rejected !== want.rejected) begin
        $error("rejected: expected %0b, got %0b", want.rejected, got.rejected);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [HOLD_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode = '0;
  logic [AMT_W-1:0]  in_amount = '0;
  logic              in_end_stop = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [COIL_W-1:0] out_coils;
  logic              out_led;
  logic              out_busy_res;
  logic [ANG_W-1:0]  out_angle;
  logic              out_rejected;

  stepper_shadow shadow = new();
  bit tx_calm;
  int n_settings;

  stepper_angle_positioner #(
    .WRAP_DEGREES  (WRAP_DEG),
    .STEPS_PER_TURN(STEPS_REV)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_amount   (in_amount),
    .in_end_stop (in_end_stop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_coils   (out_coils),
    .out_led     (out_led),
    .out_busy_res(out_busy_res),
    .out_angle   (out_angle),
    .out_rejected(out_rejected)
  );

  always #1 clk = ~clk;

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: check each accepted result and stall in random bursts.
  int rx_stall_left = 0;
  int rx_mood_left = 0;
  bit rx_calm = 1'b0;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      shadow.check_result('{out_coils, out_led, out_busy_res, out_angle, out_rejected});
    if (rx_mood_left == 0) begin
      rx_calm      = ($urandom_range(0, 3) == 0);
      rx_mood_left = $urandom_range(20, 200);
    end else begin
      rx_mood_left--;
    end
    if (rx_stall_left > 0) begin
      out_stall <= 1'b1;
      rx_stall_left--;
    end else begin
      out_stall <= 1'b0;
      rx_stall_left = rx_calm ? 0 : pick_gap();
    end
  end

  // Presents one request after an optional gap and waits until it is taken.
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [AMT_W-1:0] amount,
                              input logic end_stop);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_amount   <= amount;
    in_end_stop <= end_stop;
    do @(posedge clk); while (in_stall);
    shadow.note_request(mode, amount, end_stop);
  endtask

  // Holds off new requests until every outstanding result is back.
  task automatic drain();
    in_valid <= 1'b0;
    while (shadow.owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_hold(input logic [HOLD_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow.set_hold(value);
    n_settings++;
  endtask

  task automatic tick_until_idle(input logic end_stop);
    while (shadow.is_busy()) send_request(MODE_TICK, AMT_W'($urandom), end_stop);
  endtask

  // Small move near the current angle, coded as set, increment or decrement,
  // padded with whole turns so the upper amount bits see use.
  task automatic send_small_move();
    int delta;
    int dest;
    int base;
    int turns;
    int kind;
    int cur;
    cur   = shadow.angle_now;
    delta = $urandom_range(0, 16) - 8;
    dest  = cur + delta;
    if (dest < 0 || dest >= WRAP_DEG) dest = cur - delta;
    kind = $urandom_range(0, 2);
    if (kind == 0) base = dest;
    else if (kind == 1) base = (dest - cur + WRAP_DEG) % WRAP_DEG;
    else base = (cur - dest + WRAP_DEG) % WRAP_DEG;
    turns = $urandom_range(0, 2);
    while (base + turns * WRAP_DEG > 1023) turns--;
    send_request(kind == 0 ? MODE_SET : (kind == 1 ? MODE_INC : MODE_DEC),
                 AMT_W'(base + turns * WRAP_DEG), 1'($urandom));
  endtask

  task automatic send_random_item();
    int r;
    r = $urandom_range(0, 99);
    if (shadow.is_busy()) begin
      // Mostly ticks; during homing the end-stop usually still reads high.
      if (r < 85)
        send_request(MODE_TICK, AMT_W'($urandom),
                     shadow.motion == MOT_HOME ? ($urandom_range(0, 9) < 7) : 1'($urandom));
      else if (r < 95)
        send_request(MODE_W'($urandom_range(MODE_SET, MODE_HOME)), AMT_W'($urandom),
                     1'($urandom));
      else
        send_request(MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
                     AMT_W'($urandom), 1'($urandom));
    end else begin
      if (r < 10)
        send_request(MODE_TICK, AMT_W'($urandom), 1'($urandom));
      else if (r < 15)
        send_request(MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
                     AMT_W'($urandom), 1'($urandom));
      else if (r < 22)
        send_request(MODE_HOME, AMT_W'($urandom), 1'($urandom));
      else
        send_small_move();
    end
  endtask

  task automatic random_phase(input int n_items, input bit calm);
    tx_calm = calm;
    repeat (n_items) send_random_item();
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset hold count: idle ticks, unused codes,
    // moves to the current step, then refusals while a step is under way.
    tx_calm = 1'b0;
    send_request(MODE_TICK, '0, 1'b0);
    send_request(MODE_TICK, '1, 1'b1);
    send_request(MODE_UNUSED_FIRST, '1, 1'b1);
    send_request(MODE_UNUSED_FIRST + 3'd1, '0, 1'b0);
    send_request(MODE_UNUSED_LAST, 10'd512, 1'b1);
    send_request(MODE_SET, 10'd0, 1'b0);
    send_request(MODE_SET, 10'd350, 1'b1);
    send_request(MODE_INC, 10'd700, 1'b0);
    send_request(MODE_DEC, 10'd0, 1'b1);
    send_request(MODE_SET, 10'd1, 1'b0);
    send_request(MODE_INC, 10'd5, 1'b0);
    send_request(MODE_DEC, 10'd1, 1'b1);
    send_request(MODE_HOME, '0, 1'b1);
    send_request(MODE_SET, '1, 1'b0);
    send_request(MODE_UNUSED_LAST, '1, 1'b0);
    repeat (6) send_request(MODE_TICK, AMT_W'($urandom), 1'($urandom));
    random_phase(60, 1'b0);

    // Hold of zero: home to zero, wrap below zero and back over the top,
    // then one homing step.
    write_hold('0);
    tick_until_idle(1'b0);
    send_request(MODE_HOME, 10'd0, 1'b1);
    tick_until_idle(1'b0);
    send_request(MODE_DEC, 10'd690, 1'b0);
    tick_until_idle(1'b1);
    send_request(MODE_INC, 10'd690, 1'b1);
    tick_until_idle(1'b0);
    send_request(MODE_HOME, 10'd0, 1'b1);
    send_request(MODE_TICK, 10'd0, 1'b1);
    tick_until_idle(1'b0);

    write_hold(16'd1);
    random_phase(80, 1'b0);
    write_hold(16'hFFFF);
    random_phase(25, 1'b0);
    write_hold(16'd2);
    random_phase(80, 1'b0);
    write_hold(16'd1);
    random_phase(80, 1'b1);
    write_hold(16'd3);
    random_phase(70, 1'b0);
    write_hold(HOLD_W'($urandom_range(1, 6)));
    random_phase(70, 1'b0);
    write_hold(16'd1);
    random_phase(55, 1'b0);

    // Let the pipeline empty, then watch for stray results.
    in_valid <= 1'b0;
    waited = 0;
    while (shadow.owed_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (shadow.owed_results.size() != 0) begin
      $error("%0d results never arrived", shadow.owed_results.size());
      shadow.mismatches += shadow.owed_results.size();
    end
    repeat (12) @(posedge clk);

    $display("Covered %0d requests and %0d results across %0d hold settings,",
             shadow.n_requests, shadow.n_results, n_settings + 1);
    $display("including %0d commands refused while busy and %0d homing runs.",
             shadow.n_refused, shadow.n_homing);
    if (shadow.mismatches == 0) begin
      $display("tb_stepper_angle_positioner: PASS");
    end else begin
      $display("tb_stepper_angle_positioner: FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb_stepper_angle_positioner: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/sap_pkg.sv
design/sap_prep.sv
design/sap_core.sv
design/stepper_angle_positioner.sv
verif/tb_stepper_angle_positioner.sv
